[rtl/core/cps_pkg.sv]
// ----------------------------------------------------------------------------
// cps_pkg
// Shared constants, codes and control/status types of the column pair
// score unit.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int MAX_SEQS      = 64;
  localparam int ALPHABET_SIZE = 20;

  localparam int LETTER_W  = 5;
  localparam int MATRIX_W  = 12;
  localparam int GAP_W     = 12;
  localparam int LIMIT_W   = 7;
  localparam int SCORE_W   = 19;
  localparam int PAIR_W    = 11;
  localparam int COUNT_W   = $clog2(MAX_SEQS + 1);
  localparam int SUM_W     = 24;
  localparam int PROD_W    = MATRIX_W + COUNT_W + 1;
  localparam int K_W       = $clog2(ALPHABET_SIZE);
  localparam int MATRIX_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int MATRIX_AW    = $clog2(MATRIX_DEPTH);
  localparam int PERCENT      = 100;
  localparam int GAPPY_W      = LIMIT_W + COUNT_W;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_GAP_SCORE = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_GAP_LIMIT = 3'd4;
  localparam logic [LIMIT_W-1:0] GAP_LIMIT_RESET = 7'd20;

  localparam logic CMD_MATRIX  = 1'b0;
  localparam logic CMD_RESIDUE = 1'b1;

  typedef struct packed {
    logic take_item;
    logic scan_issue;
    logic commit_letter;
    logic div_start;
    logic load_out;
  } cps_ctrl_t;

  typedef struct packed {
    logic in_scan;
    logic in_last;
    logic last_q;
    logic scan_done;
    logic pipe_busy;
    logic div_done;
    logic out_free;
  } cps_stat_t;

endpackage

[rtl/core/cps_ram.sv]
// ----------------------------------------------------------------------------
// cps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/cps_divider.sv]
// ----------------------------------------------------------------------------
// cps_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cps_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cps_pkg::SUM_W-1:0]  dividend,
  input  logic [cps_pkg::PAIR_W-1:0] divisor,
  output logic [cps_pkg::SUM_W-1:0]  quotient,
  output logic                      done
);
  import cps_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [PAIR_W-1:0] rem;
  logic [PAIR_W-1:0] dvs;
  logic [PAIR_W:0]   shifted;
  logic [PAIR_W+1:0] diff;

  assign shifted = {rem, quotient[SUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!diff[PAIR_W+1]) begin
          rem      <= diff[PAIR_W-1:0];
          quotient <= {quotient[SUM_W-2:0], 1'b1};
        end else begin
          rem      <= shifted[PAIR_W-1:0];
          quotient <= {quotient[SUM_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/cps_datapath.sv]
// ----------------------------------------------------------------------------
// cps_datapath
// Score matrix, per-letter counts, pair accumulation pipeline, mean
// divider and result register.
// ----------------------------------------------------------------------------
module cps_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  cps_pkg::cps_ctrl_t                ctrl,
  output cps_pkg::cps_stat_t                stat,
  input  logic signed [cps_pkg::GAP_W-1:0]  gap_score,
  input  logic [cps_pkg::LIMIT_W-1:0]       gap_limit_percent,
  input  logic                              cmd,
  input  logic [cps_pkg::LETTER_W-1:0]      row_letter,
  input  logic [cps_pkg::LETTER_W-1:0]      col_letter,
  input  logic signed [cps_pkg::MATRIX_W-1:0] matrix_value,
  input  logic [cps_pkg::LETTER_W-1:0]      residue_letter,
  input  logic                              is_gap,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cps_pkg::SCORE_W-1:0] score,
  output logic [cps_pkg::PAIR_W-1:0]        pair_count,
  output logic [cps_pkg::COUNT_W-1:0]       gap_count,
  output logic                              too_gappy,
  output logic                              overflow
);
  import cps_pkg::*;

  logic [COUNT_W-1:0]        counts [ALPHABET_SIZE];
  logic [COUNT_W-1:0]        items_seen;
  logic [COUNT_W-1:0]        gaps_seen;
  logic [PAIR_W-1:0]         pairs_seen;
  logic signed [SUM_W-1:0]   pair_sum;
  logic                      overflowed;
  logic [LETTER_W-1:0]       letter_q;
  logic                      last_q;
  logic [MATRIX_AW-1:0]      row_base;
  logic [K_W-1:0]            k;
  logic                      v1;
  logic                      v2;
  logic [COUNT_W-1:0]        c1;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SCORE_W-1:0] gap_term;
  logic                      gappy;

  logic                      full;
  logic                      letter_ok;
  logic                      row_ok;
  logic                      col_ok;
  logic                      mat_we;
  logic [MATRIX_AW-1:0]      waddr;
  logic [MATRIX_AW-1:0]      raddr;
  logic signed [MATRIX_W-1:0] rdata;
  logic [SUM_W-1:0]          sum_mag;
  logic [SUM_W-1:0]          quotient;
  logic                      div_done;
  logic signed [SCORE_W-1:0] mean;
  logic [GAPPY_W-1:0]        gap_lhs;
  logic [GAPPY_W-1:0]        gap_rhs;
  logic signed [GAP_W+COUNT_W:0] gap_prod;

  assign full      = items_seen >= COUNT_W'(MAX_SEQS);
  assign letter_ok = {1'b0, residue_letter} < (LETTER_W + 1)'(ALPHABET_SIZE);
  assign row_ok    = {1'b0, row_letter} < (LETTER_W + 1)'(ALPHABET_SIZE);
  assign col_ok    = {1'b0, col_letter} < (LETTER_W + 1)'(ALPHABET_SIZE);
  assign mat_we    = ctrl.take_item && (cmd == CMD_MATRIX) && row_ok && col_ok;
  assign waddr     = MATRIX_AW'(row_letter) * MATRIX_AW'(ALPHABET_SIZE)
                     + MATRIX_AW'(col_letter);
  assign raddr     = row_base + MATRIX_AW'(k);

  cps_ram #(
    .WIDTH (MATRIX_W),
    .DEPTH (MATRIX_DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (mat_we),
    .waddr (waddr),
    .wdata (matrix_value),
    .re    (ctrl.scan_issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sum_mag = pair_sum[SUM_W-1] ? SUM_W'(-pair_sum) : SUM_W'(pair_sum);

  cps_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (sum_mag),
    .divisor  (pairs_seen),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    if (pairs_seen == '0) begin
      mean = '0;
    end else if (pair_sum[SUM_W-1]) begin
      mean = -signed'(quotient[SCORE_W-1:0]);
    end else begin
      mean = signed'(quotient[SCORE_W-1:0]);
    end
  end

  assign gap_prod = gap_score * signed'({1'b0, gaps_seen});
  assign gap_lhs  = GAPPY_W'(gaps_seen) * GAPPY_W'(PERCENT);
  assign gap_rhs  = GAPPY_W'(gap_limit_percent) * GAPPY_W'(items_seen);

  assign stat.in_scan   = (cmd == CMD_RESIDUE) && !full && !is_gap && letter_ok;
  assign stat.in_last   = (cmd == CMD_RESIDUE) && last;
  assign stat.last_q    = last_q;
  assign stat.scan_done = (k == K_W'(ALPHABET_SIZE - 1));
  assign stat.pipe_busy = v1 || v2;
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst || ctrl.load_out) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        counts[i] <= '0;
      end
      items_seen <= '0;
      gaps_seen  <= '0;
      pairs_seen <= '0;
      pair_sum   <= '0;
      overflowed <= 1'b0;
    end else begin
      if (ctrl.take_item && (cmd == CMD_RESIDUE)) begin
        if (full) begin
          overflowed <= 1'b1;
        end else begin
          items_seen <= items_seen + 1'b1;
          if (is_gap) begin
            gaps_seen <= gaps_seen + 1'b1;
          end
        end
      end
      if (ctrl.scan_issue) begin
        pairs_seen <= pairs_seen + PAIR_W'(counts[k]);
      end
      if (v2) begin
        pair_sum <= pair_sum + SUM_W'(prod);
      end
      if (ctrl.commit_letter) begin
        counts[letter_q[K_W-1:0]] <= counts[letter_q[K_W-1:0]] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      v1 <= ctrl.scan_issue;
      v2 <= v1;
      if (ctrl.take_item) begin
        k <= '0;
      end else if (ctrl.scan_issue) begin
        k <= k + 1'b1;
      end
      if (ctrl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_item) begin
      letter_q <= residue_letter;
      last_q   <= last;
      row_base <= MATRIX_AW'(residue_letter) * MATRIX_AW'(ALPHABET_SIZE);
    end
    if (ctrl.scan_issue) begin
      c1 <= counts[k];
    end
    if (v1) begin
      prod <= rdata * signed'({1'b0, c1});
    end
    if (ctrl.div_start) begin
      gap_term <= gap_prod[SCORE_W-1:0];
      gappy    <= gap_lhs > gap_rhs;
    end
    if (ctrl.load_out) begin
      score      <= gap_term + mean;
      pair_count <= pairs_seen;
      gap_count  <= gaps_seen;
      too_gappy  <= gappy;
      overflow   <= overflowed;
    end
  end

endmodule

[rtl/core/cps_ctrl.sv]
// ----------------------------------------------------------------------------
// cps_ctrl
// Sequencer: item intake, row scan, pipeline drain, division and result
// hand-off.
// ----------------------------------------------------------------------------
module cps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cps_pkg::cps_stat_t stat,
  output cps_pkg::cps_ctrl_t ctrl
);
  import cps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUTPUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready           = (state == ST_IDLE);
  assign ctrl.take_item     = in_valid && in_ready;
  assign ctrl.scan_issue    = (state == ST_SCAN);
  assign ctrl.commit_letter = (state == ST_DRAIN) && !stat.pipe_busy;
  assign ctrl.div_start     = (state == ST_DIV_START);
  assign ctrl.load_out      = (state == ST_OUTPUT) && stat.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (ctrl.take_item) begin
          priority if (stat.in_scan) begin
            state_next = ST_SCAN;
          end else if (stat.in_last) begin
            state_next = ST_DIV_START;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = stat.last_q ? ST_DIV_START : ST_IDLE;
        end
      end
      ST_DIV_START: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/column_pair_score_unit.sv]
// Sequence: a matrix write or an unscored residue returns straight to idle; a scored residue
// goes through intake, a row scan of the matrix RAM and a drain of the product pipeline.
// A last residue adds a division of the pair sum by the pair count before the result registers;
// a second result holds intake until the first one is taken.
// Intake stays closed until a scored residue has been committed; the matrix has a single read port.
// Reset clears the column state and the configuration registers; the score matrix is not cleared.
// ----------------------------------------------------------------------------
// column_pair_score_unit
// Sum-of-pairs score of one alignment column with APB configuration.
// ----------------------------------------------------------------------------
module column_pair_score_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cps_pkg::PADDR_W-1:0]         paddr,
  input  logic [cps_pkg::PDATA_W-1:0]         pwdata,
  output logic [cps_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [cps_pkg::LETTER_W-1:0]        row_letter,
  input  logic [cps_pkg::LETTER_W-1:0]        col_letter,
  input  logic signed [cps_pkg::MATRIX_W-1:0] matrix_value,
  input  logic [cps_pkg::LETTER_W-1:0]        residue_letter,
  input  logic                                is_gap,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cps_pkg::SCORE_W-1:0]  score,
  output logic [cps_pkg::PAIR_W-1:0]          pair_count,
  output logic [cps_pkg::COUNT_W-1:0]         gap_count,
  output logic                                too_gappy,
  output logic                                overflow
);
  import cps_pkg::*;

  logic signed [GAP_W-1:0] gap_score;
  logic [LIMIT_W-1:0]      gap_limit_percent;
  logic                    wr_en;
  cps_ctrl_t               ctrl;
  cps_stat_t               stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_score         <= '0;
      gap_limit_percent <= GAP_LIMIT_RESET;
    end else if (wr_en) begin
      if (paddr == ADDR_GAP_SCORE) begin
        gap_score <= pwdata[GAP_W-1:0];
      end
      if (paddr == ADDR_GAP_LIMIT) begin
        gap_limit_percent <= pwdata[LIMIT_W-1:0];
      end
    end
  end

  always_comb begin
    priority if (paddr == ADDR_GAP_SCORE) begin
      prdata = PDATA_W'(gap_score);
    end else if (paddr == ADDR_GAP_LIMIT) begin
      prdata = PDATA_W'(gap_limit_percent);
    end else begin
      prdata = '0;
    end
  end

  cps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  cps_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .stat              (stat),
    .gap_score         (gap_score),
    .gap_limit_percent (gap_limit_percent),
    .cmd               (cmd),
    .row_letter        (row_letter),
    .col_letter        (col_letter),
    .matrix_value      (matrix_value),
    .residue_letter    (residue_letter),
    .is_gap            (is_gap),
    .last              (last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .score             (score),
    .pair_count        (pair_count),
    .gap_count         (gap_count),
    .too_gappy         (too_gappy),
    .overflow          (overflow)
  );

  a_div_blocks_intake: assert property (@(posedge clk) disable iff (rst)
    ctrl.div_start |=> !in_ready)
    else $error("intake open during division");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |=> out_valid)
    else $error("result load without valid");

  a_done_outside_scan: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> !ctrl.scan_issue && !in_ready)
    else $error("divider done while scanning or idle");

  a_commit_after_drain: assert property (@(posedge clk) disable iff (rst)
    ctrl.commit_letter |-> !ctrl.scan_issue && !ctrl.take_item)
    else $error("letter commit overlaps scan or intake");

endmodule
